FILE: design/gdad_pkg.sv
`default_nettype none
package gdad_pkg;

  // field widths
  localparam int YEAR_BITS  = 16;
  localparam int COUNT_BITS = 16;
  localparam int DAY_BITS   = 5;
  localparam int MONTH_BITS = 4;
  localparam int STAT_BITS  = 2;

  // day + count needs one bit above the wider of the two
  localparam int DSUM_BITS = ((COUNT_BITS > DAY_BITS) ? COUNT_BITS : DAY_BITS) + 1;

  localparam int R400_BITS = 9;
  localparam int R100_BITS = 7;

  // year / 400 by reciprocal multiply: exact for every YEAR_BITS-bit year
  localparam int LEAP_CYCLE = 400;
  localparam int RCP_SHIFT  = YEAR_BITS + R400_BITS;
  localparam int PROD_BITS  = 2 * YEAR_BITS + 1;
  localparam int QUO_BITS   = YEAR_BITS - 7;
  localparam longint unsigned RCP_FULL =
    ((64'd1 << RCP_SHIFT) + 64'(LEAP_CYCLE - 1)) / 64'(LEAP_CYCLE);
  localparam logic [YEAR_BITS:0] RCP_MUL = (YEAR_BITS+1)'(RCP_FULL);

  localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};

  localparam logic [R400_BITS-1:0] R400_LAST = R400_BITS'(399);
  localparam logic [R100_BITS-1:0] R100_LAST = R100_BITS'(99);

  localparam logic [MONTH_BITS-1:0] MONTH_JAN = MONTH_BITS'(1);
  localparam logic [MONTH_BITS-1:0] MONTH_FEB = MONTH_BITS'(2);
  localparam logic [MONTH_BITS-1:0] MONTH_DEC = MONTH_BITS'(12);

  localparam logic [MONTH_BITS-1:0] SHORT_MONTHS [4] = '{
    MONTH_BITS'(4), MONTH_BITS'(6), MONTH_BITS'(9), MONTH_BITS'(11)
  };

  localparam logic [DAY_BITS-1:0] LEN_31 = DAY_BITS'(31);
  localparam logic [DAY_BITS-1:0] LEN_30 = DAY_BITS'(30);
  localparam logic [DAY_BITS-1:0] LEN_29 = DAY_BITS'(29);
  localparam logic [DAY_BITS-1:0] LEN_28 = DAY_BITS'(28);

  typedef enum logic [STAT_BITS-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_INVALID  = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  // one classified item handed from front to back
  typedef struct packed {
    logic [DSUM_BITS-1:0]  day;
    logic [MONTH_BITS-1:0] month;
    logic [YEAR_BITS-1:0]  year;
    logic [R400_BITS-1:0]  r400;
    logic [R100_BITS-1:0]  r100;
    logic                  invalid;
  } q_entry_t;

  localparam int Q_DEPTH = 2;

  function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                    input logic leap);
    logic [DAY_BITS-1:0] len;
    len = LEN_31;
    for (int i = 0; i < 4; i++) begin
      if (m == SHORT_MONTHS[i]) len = LEN_30;
    end
    if (m == MONTH_FEB) len = leap ? LEN_29 : LEN_28;
    return len;
  endfunction

endpackage
`default_nettype wire

FILE: design/gdad_front.sv
`default_nettype none
module gdad_front (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [gdad_pkg::DAY_BITS-1:0]   in_day,
  input  wire logic [gdad_pkg::MONTH_BITS-1:0] in_month,
  input  wire logic [gdad_pkg::YEAR_BITS-1:0]  in_year,
  input  wire logic [gdad_pkg::COUNT_BITS-1:0] in_days_to_add,
  output logic                                 push_valid,
  input  wire logic                            push_ready,
  output gdad_pkg::q_entry_t                   push_data
);
  import gdad_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_QUO, F_REM, F_PUSH} fstate_t;

  fstate_t               state_r, state_nxt;
  logic [DSUM_BITS-1:0]  day_r, day_nxt;
  logic [MONTH_BITS-1:0] month_r, month_nxt;
  logic [YEAR_BITS-1:0]  year_r, year_nxt;
  logic [QUO_BITS-1:0]   quo_r, quo_nxt;
  logic [R400_BITS-1:0]  r400_r, r400_nxt;
  logic                  invalid_r, invalid_nxt;

  logic                  date_bad;
  logic [PROD_BITS-1:0]  prod;
  logic [YEAR_BITS-1:0]  quo_x400;
  logic [R100_BITS-1:0]  r100;

  assign date_bad = (in_day == '0) || (in_month == '0) || (in_month > MONTH_DEC);

  // year / 400 by reciprocal multiply, then back to the multiple of 400
  assign prod     = PROD_BITS'(year_r) * PROD_BITS'(RCP_MUL);
  assign quo_x400 = YEAR_BITS'(quo_r) * YEAR_BITS'(LEAP_CYCLE);

  // mod 100 from mod 400
  always_comb begin
    if (r400_r >= R400_BITS'(300))      r100 = R100_BITS'(r400_r - R400_BITS'(300));
    else if (r400_r >= R400_BITS'(200)) r100 = R100_BITS'(r400_r - R400_BITS'(200));
    else if (r400_r >= R400_BITS'(100)) r100 = R100_BITS'(r400_r - R400_BITS'(100));
    else                                r100 = R100_BITS'(r400_r);
  end

  assign in_ready   = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);

  always_comb begin
    push_data.day     = day_r;
    push_data.month   = month_r;
    push_data.year    = year_r;
    push_data.r400    = r400_r;
    push_data.r100    = r100;
    push_data.invalid = invalid_r;
  end

  // next state
  always_comb begin
    state_nxt   = state_r;
    day_nxt     = day_r;
    month_nxt   = month_r;
    year_nxt    = year_r;
    quo_nxt     = quo_r;
    r400_nxt    = r400_r;
    invalid_nxt = invalid_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          month_nxt   = in_month;
          year_nxt    = in_year;
          invalid_nxt = date_bad;
          r400_nxt    = '0;
          if (date_bad) begin
            day_nxt   = DSUM_BITS'(in_day);
            state_nxt = F_PUSH;
          end else begin
            day_nxt   = DSUM_BITS'(in_day) + DSUM_BITS'(in_days_to_add);
            state_nxt = F_QUO;
          end
        end
      end
      F_QUO: begin
        quo_nxt   = QUO_BITS'(prod >> RCP_SHIFT);
        state_nxt = F_REM;
      end
      F_REM: begin
        r400_nxt  = R400_BITS'(year_r - quo_x400);
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (push_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    day_r     <= day_nxt;
    month_r   <= month_nxt;
    year_r    <= year_nxt;
    quo_r     <= quo_nxt;
    r400_r    <= r400_nxt;
    invalid_r <= invalid_nxt;
  end

  // remainder is reduced by the time the item is handed on
  a_r400_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_PUSH) |-> (r400_r <= R400_LAST))
    else $error("front: remainder mod 400 out of range");

endmodule
`default_nettype wire

FILE: design/gdad_queue.sv
`default_nettype none
module gdad_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire gdad_pkg::q_entry_t push_data,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output gdad_pkg::q_entry_t      pop_data
);
  import gdad_pkg::*;

  localparam int PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(Q_DEPTH + 1);

  q_entry_t              mem_r [Q_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_BITS-1:0]   count_r;
  logic                  do_push, do_pop;

  assign push_ready = (count_r != CNT_BITS'(Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_BITS'(Q_DEPTH)))
    else $error("queue: fill count beyond depth");

endmodule
`default_nettype wire

FILE: design/gdad_back.sv
`default_nettype none
module gdad_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             pop_valid,
  output logic                                  pop_ready,
  input  wire gdad_pkg::q_entry_t               pop_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [gdad_pkg::DAY_BITS-1:0]         out_day,
  output logic [gdad_pkg::MONTH_BITS-1:0]       out_month,
  output logic [gdad_pkg::YEAR_BITS-1:0]        out_year,
  output logic [gdad_pkg::STAT_BITS-1:0]        out_status
);
  import gdad_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_WALK, B_DONE} bstate_t;

  bstate_t               state_r;
  logic [DSUM_BITS-1:0]  day_r;
  logic [MONTH_BITS-1:0] month_r;
  logic [YEAR_BITS-1:0]  year_r;
  logic [R400_BITS-1:0]  r400_r;
  logic [R100_BITS-1:0]  r100_r;
  status_t               stat_r;

  logic                  out_valid_r;
  logic [DAY_BITS-1:0]   out_day_r;
  logic [MONTH_BITS-1:0] out_month_r;
  logic [YEAR_BITS-1:0]  out_year_r;
  status_t               out_stat_r;

  logic                  leap;
  logic [DAY_BITS-1:0]   len;
  logic                  fits;
  logic                  out_free;

  assign leap     = ((year_r[1:0] == 2'b00) && (r100_r != '0)) || (r400_r == '0);
  assign len      = month_len(month_r, leap);
  assign fits     = (day_r <= DSUM_BITS'(len));
  assign out_free = !out_valid_r || out_ready;

  assign pop_ready  = (state_r == B_IDLE);
  assign out_valid  = out_valid_r;
  assign out_day    = out_day_r;
  assign out_month  = out_month_r;
  assign out_year   = out_year_r;
  assign out_status = out_stat_r;

  // one month removed per cycle, result register at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != B_DONE)) out_valid_r <= 1'b0;
      case (state_r)
        B_IDLE: begin
          if (pop_valid) begin
            day_r   <= pop_data.day;
            month_r <= pop_data.month;
            year_r  <= pop_data.year;
            r400_r  <= pop_data.r400;
            r100_r  <= pop_data.r100;
            if (pop_data.invalid) begin
              stat_r  <= STATUS_INVALID;
              state_r <= B_DONE;
            end else begin
              stat_r  <= STATUS_OK;
              state_r <= B_WALK;
            end
          end
        end
        B_WALK: begin
          if (fits) begin
            state_r <= B_DONE;
          end else begin
            day_r <= day_r - DSUM_BITS'(len);
            if (month_r == MONTH_DEC) begin
              month_r <= MONTH_JAN;
              if (year_r == YEAR_MAX) begin
                year_r <= '0;
                r400_r <= '0;
                r100_r <= '0;
                stat_r <= STATUS_OVERFLOW;
              end else begin
                year_r <= year_r + 1'b1;
                r400_r <= (r400_r == R400_LAST) ? '0 : r400_r + 1'b1;
                r100_r <= (r100_r == R100_LAST) ? '0 : r100_r + 1'b1;
              end
            end else begin
              month_r <= month_r + 1'b1;
            end
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_day_r   <= day_r[DAY_BITS-1:0];
            out_month_r <= month_r;
            out_year_r  <= year_r;
            out_stat_r  <= stat_r;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  // a walked result has a month from 1 to 12 and a nonzero day
  a_result_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_stat_r != STATUS_INVALID)) |->
      ((out_month_r >= MONTH_JAN) && (out_month_r <= MONTH_DEC) && (out_day_r != '0)))
    else $error("back: result date out of range");

  // the walk never drives the day to zero
  a_walk_day: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_WALK) |-> (day_r != '0))
    else $error("back: day reached zero during walk");

  // year remainders stay within their ranges during the walk
  a_rem_link: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_WALK) |-> (r400_r <= R400_LAST) && (r100_r <= R100_LAST))
    else $error("back: year remainders out of range");

endmodule
`default_nettype wire

FILE: design/gregorian_date_add_days_top.sv
`default_nettype none
// Gregorian date adder.
// Input channel (in_valid/in_ready): a start date in_day, in_month, in_year and a
// day count in_days_to_add. Output channel (out_valid/out_ready): the resulting
// date out_day, out_month, out_year and out_status (0 ok, 1 invalid start date
// returned unchanged, 2 year wrapped past its maximum).
// The front stage takes one transfer, checks the date and reduces the year mod 400
// by a reciprocal multiply (F_QUO, then F_REM), then pushes into a two-entry queue.
// The back stage removes one whole month per cycle until the day fits.
// A count of N days walks about N / 30.4 months, up to about 2160 months for the
// largest count. Invalid dates skip the walk. While the back walks one item, the
// front takes the next one and overlaps it through the queue.
// Reset empties the queue and drops any item in flight; out_valid goes low.
// When the receiver stalls, the result is held in the output register, the back
// stage finishes its next item and waits, and the queue and front fill up before
// in_ready drops.
module gregorian_date_add_days_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [gdad_pkg::DAY_BITS-1:0]   in_day,
  input  wire logic [gdad_pkg::MONTH_BITS-1:0] in_month,
  input  wire logic [gdad_pkg::YEAR_BITS-1:0]  in_year,
  input  wire logic [gdad_pkg::COUNT_BITS-1:0] in_days_to_add,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [gdad_pkg::DAY_BITS-1:0]        out_day,
  output logic [gdad_pkg::MONTH_BITS-1:0]      out_month,
  output logic [gdad_pkg::YEAR_BITS-1:0]       out_year,
  output logic [gdad_pkg::STAT_BITS-1:0]       out_status
);
  import gdad_pkg::*;

  logic     push_valid, push_ready;
  q_entry_t push_data;
  logic     pop_valid, pop_ready;
  q_entry_t pop_data;

  gdad_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_day         (in_day),
    .in_month       (in_month),
    .in_year        (in_year),
    .in_days_to_add (in_days_to_add),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_data      (push_data)
  );

  gdad_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  gdad_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_day    (out_day),
    .out_month  (out_month),
    .out_year   (out_year),
    .out_status (out_status)
  );

endmodule
`default_nettype wire

FILE: tb/tb_gregorian_date_add_days_top.sv
`timescale 1ns / 100ps

module tb_gregorian_date_add_days_top;
  import gdad_pkg::*;

  // one resulting date as the block should return it
  typedef struct packed {
    logic [DAY_BITS-1:0]   day;
    logic [MONTH_BITS-1:0] month;
    logic [YEAR_BITS-1:0]  year;
    status_t               status;
  } date_result_t;

  // one directed row; when fixed is set, want holds the result written out by hand
  typedef struct packed {
    logic [DAY_BITS-1:0]   day;
    logic [MONTH_BITS-1:0] month;
    logic [YEAR_BITS-1:0]  year;
    logic [COUNT_BITS-1:0] count;
    bit                    fixed;
    date_result_t          want;
  } date_case_t;

  localparam date_result_t PREDICT = '{5'd0, 4'd0, 16'd0, STATUS_OK};
  localparam int NUM_DIRECTED = 25;
  localparam int NUM_RANDOM   = 245;
  localparam int PRESSURE_AT  = 60;    // result count at which the long hold-off starts
  localparam int PRESSURE_LEN = 2500;
  localparam int TAIL_CYCLES  = 2500;  // longest month walk plus margin

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [DAY_BITS-1:0]   in_day = '0;
  logic [MONTH_BITS-1:0] in_month = '0;
  logic [YEAR_BITS-1:0]  in_year = '0;
  logic [COUNT_BITS-1:0] in_days_to_add = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DAY_BITS-1:0]   out_day;
  logic [MONTH_BITS-1:0] out_month;
  logic [YEAR_BITS-1:0]  out_year;
  logic [STAT_BITS-1:0]  out_status;

  date_result_t expected_dates[$];
  int unsigned  failures = 0;
  int unsigned  dates_offered = 0;
  int unsigned  results_taken = 0;

  // invalid dates, extremes, leap rules, short months, overflow, day past month end
  date_case_t directed_cases [NUM_DIRECTED] = '{
    '{5'd0,  4'd1,  16'd2000,  16'd5,     1'b1, '{5'd0,  4'd1,  16'd2000,  STATUS_INVALID}},
    '{5'd15, 4'd0,  16'd2000,  16'd10,    1'b1, '{5'd15, 4'd0,  16'd2000,  STATUS_INVALID}},
    '{5'd10, 4'd13, 16'd2020,  16'd3,     1'b1, '{5'd10, 4'd13, 16'd2020,  STATUS_INVALID}},
    '{5'd31, 4'd15, 16'd65535, 16'd65535, 1'b1, '{5'd31, 4'd15, 16'd65535, STATUS_INVALID}},
    '{5'd0,  4'd0,  16'd0,     16'd0,     1'b1, '{5'd0,  4'd0,  16'd0,     STATUS_INVALID}},
    '{5'd1,  4'd1,  16'd0,     16'd0,     1'b1, '{5'd1,  4'd1,  16'd0,     STATUS_OK}},
    '{5'd31, 4'd12, 16'd65535, 16'd1,     1'b1, '{5'd1,  4'd1,  16'd0,     STATUS_OVERFLOW}},
    '{5'd31, 4'd12, 16'd65535, 16'd0,     1'b1, '{5'd31, 4'd12, 16'd65535, STATUS_OK}},
    '{5'd31, 4'd4,  16'd2023,  16'd0,     1'b1, '{5'd1,  4'd5,  16'd2023,  STATUS_OK}},
    '{5'd28, 4'd2,  16'd2024,  16'd1,     1'b1, '{5'd29, 4'd2,  16'd2024,  STATUS_OK}},
    '{5'd28, 4'd2,  16'd2023,  16'd1,     1'b1, '{5'd1,  4'd3,  16'd2023,  STATUS_OK}},
    '{5'd28, 4'd2,  16'd1900,  16'd1,     1'b1, '{5'd1,  4'd3,  16'd1900,  STATUS_OK}},
    '{5'd28, 4'd2,  16'd2000,  16'd1,     1'b1, '{5'd29, 4'd2,  16'd2000,  STATUS_OK}},
    '{5'd31, 4'd12, 16'd1999,  16'd1,     1'b1, '{5'd1,  4'd1,  16'd2000,  STATUS_OK}},
    '{5'd30, 4'd4,  16'd2021,  16'd1,     1'b0, PREDICT},
    '{5'd30, 4'd6,  16'd2021,  16'd1,     1'b0, PREDICT},
    '{5'd30, 4'd9,  16'd2021,  16'd1,     1'b0, PREDICT},
    '{5'd30, 4'd11, 16'd2021,  16'd1,     1'b0, PREDICT},
    '{5'd1,  4'd1,  16'd0,     16'd65535, 1'b0, PREDICT},
    '{5'd31, 4'd12, 16'd65535, 16'd65535, 1'b0, PREDICT},
    '{5'd31, 4'd2,  16'd2023,  16'd0,     1'b0, PREDICT},
    '{5'd1,  4'd1,  16'd2024,  16'd366,   1'b0, PREDICT},
    '{5'd15, 4'd6,  16'd2024,  16'd1,     1'b0, PREDICT},
    '{5'd31, 4'd1,  16'd2100,  16'd29,    1'b0, PREDICT},
    '{5'd16, 4'd8,  16'd65500, 16'd40000, 1'b0, PREDICT}
  };

  gregorian_date_add_days_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_day        (in_day),
    .in_month      (in_month),
    .in_year       (in_year),
    .in_days_to_add(in_days_to_add),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_day       (out_day),
    .out_month     (out_month),
    .out_year      (out_year),
    .out_status    (out_status)
  );

  // leap rule: every 4th year, except centuries not divisible by 400
  function automatic bit is_leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    case (m)
      4, 6, 9, 11: return 30;
      2:           return is_leap_year(y) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  // expected result: add the count to the day, then strip whole months
  function automatic date_result_t advance_date(input logic [DAY_BITS-1:0] day,
                                                input logic [MONTH_BITS-1:0] month,
                                                input logic [YEAR_BITS-1:0] year,
                                                input logic [COUNT_BITS-1:0] count);
    date_result_t r;
    int unsigned  d;
    int unsigned  m;
    int unsigned  y;
    r = '{day, month, year, STATUS_OK};
    if (day == 0 || month == 0 || month > 12) begin
      r.status = STATUS_INVALID;
      return r;
    end
    d = day + count;
    m = month;
    y = year;
    while (d > month_days(m, y)) begin
      d = d - month_days(m, y);
      m = m + 1;
      if (m > 12) begin
        m = 1;
        // year wraps to zero and the walk carries on
        if (y == YEAR_MAX) begin
          y = 0;
          r.status = STATUS_OVERFLOW;
        end else begin
          y = y + 1;
        end
      end
    end
    r.day   = DAY_BITS'(d);
    r.month = MONTH_BITS'(m);
    r.year  = YEAR_BITS'(y);
    return r;
  endfunction

  // offer one date; the expectation is queued at the transfer
  task automatic offer_date(input logic [DAY_BITS-1:0] day,
                            input logic [MONTH_BITS-1:0] month,
                            input logic [YEAR_BITS-1:0] year,
                            input logic [COUNT_BITS-1:0] count,
                            input bit fixed,
                            input date_result_t want);
    int unsigned gap;
    gap = ((dates_offered / 40) % 3 == 2) ? 0 : $urandom_range(0, 16);
    dates_offered++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_day         <= day;
    in_month       <= month;
    in_year        <= year;
    in_days_to_add <= count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_dates.push_back(fixed ? want : advance_date(day, month, year, count));
  endtask

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // stimulus: reset, directed table, then random dates
  initial begin
    logic [DAY_BITS-1:0]   d;
    logic [MONTH_BITS-1:0] m;
    logic [YEAR_BITS-1:0]  y;
    logic [COUNT_BITS-1:0] c;
    int unsigned           pick;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      offer_date(directed_cases[i].day, directed_cases[i].month, directed_cases[i].year,
                 directed_cases[i].count, directed_cases[i].fixed, directed_cases[i].want);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if ($urandom_range(0, 99) < 15) begin
        // noise: any field value, invalid dates included
        d = DAY_BITS'($urandom_range(0, 31));
        m = MONTH_BITS'($urandom_range(0, 15));
        y = YEAR_BITS'($urandom_range(0, 65535));
        c = COUNT_BITS'($urandom_range(0, 65535));
      end else begin
        d = DAY_BITS'($urandom_range(1, 31));
        m = MONTH_BITS'($urandom_range(1, 12));
        pick = $urandom_range(0, 99);
        if (pick < 30)      y = YEAR_BITS'($urandom_range(0, 65535));
        else if (pick < 45) y = YEAR_BITS'($urandom_range(65500, 65535));
        else if (pick < 65) y = YEAR_BITS'(100 * $urandom_range(0, 655));
        else                y = YEAR_BITS'($urandom_range(1800, 2500));
        // mostly short walks, a few spanning the whole count range
        pick = $urandom_range(0, 99);
        if (pick < 60)      c = COUNT_BITS'($urandom_range(0, 400));
        else if (pick < 85) c = COUNT_BITS'($urandom_range(0, 3000));
        else                c = COUNT_BITS'($urandom_range(0, 65535));
      end
      offer_date(d, m, y, c, 1'b0, PREDICT);
    end
    in_valid <= 1'b0;

    while (expected_dates.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off to back up the block
  initial begin
    int unsigned stall;
    forever begin
      if (results_taken == PRESSURE_AT) stall = PRESSURE_LEN;
      else if ((results_taken / 40) % 3 == 1) stall = 0;
      else stall = $urandom_range(0, 16);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_taken++;
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    date_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_dates.size() == 0) begin
        $error("result transfer with nothing expected: %0d-%0d-%0d status %0d",
               out_year, out_month, out_day, out_status);
        failures++;
      end else begin
        want = expected_dates.pop_front();
        if (out_day !== want.day) begin
          $error("out_day mismatch: expected %0d, got %0d", want.day, out_day);
          failures++;
        end
        if (out_month !== want.month) begin
          $error("out_month mismatch: expected %0d, got %0d", want.month, out_month);
          failures++;
        end
        if (out_year !== want.year) begin
          $error("out_year mismatch: expected %0d, got %0d", want.year, out_year);
          failures++;
        end
        if (out_status !== want.status) begin
          $error("out_status mismatch: expected %0d, got %0d", want.status, out_status);
          failures++;
        end
      end
    end
  end

endmodule

FILE: gregorian_date_add_days_top.f
design/gdad_pkg.sv
design/gdad_front.sv
design/gdad_queue.sv
design/gdad_back.sv
design/gregorian_date_add_days_top.sv
tb/tb_gregorian_date_add_days_top.sv
